@@ rtl/assert_macros.svh @@
// assertion macros shared by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbl_pkg.sv @@
// shared widths, limits and register indexes of the sobel magnitude block
`timescale 1ns / 1ps
package sbl_pkg;

  localparam int MAG_W      = 19;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 12;
  localparam int CFG_DATA_W = 13;

  localparam int ROWS_MIN   = 3;
  localparam int ROWS_MAX   = 4096;
  localparam int COLS_MIN   = 3;
  localparam int ROWS_RESET = 512;
  localparam int COLS_RESET = 512;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_ROWS = 1'b0;
  localparam cfg_idx_t REG_IMAGE_COLS = 1'b1;

endpackage

@@ rtl/sbl_ifs.sv @@
// valid/ready channel interfaces: pixel stream, result stream, register writes
`timescale 1ns / 1ps
interface sbl_pix_if #(parameter int PIXEL_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_first;

  modport source (output valid, pixel, frame_first, input ready);
  modport sink   (input valid, pixel, frame_first, output ready);
endinterface

interface sbl_res_if ();
  logic                       valid;
  logic                       ready;
  logic [sbl_pkg::MAG_W-1:0]  magnitude;
  logic [sbl_pkg::ROW_W-1:0]  centre_row;
  logic [sbl_pkg::COL_W-1:0]  centre_col;
  logic                       frame_last;

  modport source (output valid, magnitude, centre_row, centre_col, frame_last, input ready);
  modport sink   (input valid, magnitude, centre_row, centre_col, frame_last, output ready);
endinterface

interface sbl_cfg_if ();
  logic                           valid;
  logic                           ready;
  sbl_pkg::cfg_idx_t              index;
  logic [sbl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sobel_gradient_magnitude_top.sv @@
// sobel 3x3 gradient magnitude over a raster pixel stream, line store in one ram
// pixel acceptance: a new pixel is taken only after the last one is through its line read
//   and, if it makes a result, after that result is loaded into the output register
// result path: line read, squares, sum, bit-serial square root (one root bit per cycle),
//   output register; a border result goes from the line read straight to the output register
// reset: rst synchronous, clears position, window, sizes (512 x 512) and handshake state;
//   line ram contents stay undefined until written, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sobel_gradient_magnitude_top #(
  parameter int MAX_COLS   = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  sbl_pix_if.sink   pixels,
  sbl_res_if.source results,
  sbl_cfg_if.sink   cfg
);

  import sbl_pkg::*;

  // datapath widths: |gx|,|gy| < 4 * 2^PIXEL_BITS
  localparam int AW   = PIXEL_BITS + 2;
  localparam int RW   = AW + 1;
  localparam int SQW  = 2 * AW;
  localparam int RADW = 2 * RW;
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int CCW  = $clog2(MAX_COLS + 1);

  localparam int COLS_RESET_EFF = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // ------------------------------------------------------------------
  // image size registers, clamped on write
  // ------------------------------------------------------------------
  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [CCW-1:0]        cols_eff;
  logic [ROWS_CFG_W-1:0] rows_wr;
  logic [COLS_CFG_W-1:0] cols_raw;
  logic [CCW-1:0]        cols_wr;
  logic                  cfg_fire;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cols_raw  = cfg.data[COLS_CFG_W-1:0];

  always_comb begin
    rows_wr = cfg.data[ROWS_CFG_W-1:0];
    if (rows_wr < ROWS_CFG_W'(ROWS_MIN)) begin
      rows_wr = ROWS_CFG_W'(ROWS_MIN);
    end else if (rows_wr > ROWS_CFG_W'(ROWS_MAX)) begin
      rows_wr = ROWS_CFG_W'(ROWS_MAX);
    end
    if (cols_raw < COLS_CFG_W'(COLS_MIN)) begin
      cols_wr = CCW'(COLS_MIN);
    end else if (32'(cols_raw) > 32'(MAX_COLS)) begin
      cols_wr = CCW'(MAX_COLS);
    end else begin
      cols_wr = CCW'(cols_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff <= ROWS_CFG_W'(ROWS_RESET);
      cols_eff <= CCW'(COLS_RESET_EFF);
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_IMAGE_ROWS: rows_eff <= rows_wr;
        REG_IMAGE_COLS: cols_eff <= cols_wr;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // raster position: wrap on entry (sizes may have shrunk), advance on transfer
  // ------------------------------------------------------------------
  logic                  in_fire;
  logic [ROW_W-1:0]      row_pos;
  logic [CAW-1:0]        col_pos;
  logic [ROWS_CFG_W-1:0] row_start;
  logic [ROWS_CFG_W-1:0] row_bump;
  logic [ROWS_CFG_W-1:0] row_cur;
  logic [ROWS_CFG_W-1:0] row_inc;
  logic [CCW-1:0]        col_start;
  logic [CCW-1:0]        col_cur;
  logic [CCW-1:0]        col_inc;
  logic [ROW_W-1:0]      row_pos_next;
  logic [CAW-1:0]        col_pos_next;

  assign pixels.ready = (state == S_IDLE);
  assign in_fire      = pixels.valid && pixels.ready;

  always_comb begin
    row_start = pixels.frame_first ? '0 : {1'b0, row_pos};
    col_start = pixels.frame_first ? '0 : CCW'(col_pos);
    if (col_start >= cols_eff) begin
      col_cur  = '0;
      row_bump = row_start + 1'b1;
    end else begin
      col_cur  = col_start;
      row_bump = row_start;
    end
    row_cur = (row_bump >= rows_eff) ? '0 : row_bump;
    col_inc = col_cur + 1'b1;
    row_inc = row_cur + 1'b1;
    if (col_inc >= cols_eff) begin
      col_pos_next = '0;
      row_pos_next = (row_inc >= rows_eff) ? '0 : ROW_W'(row_inc);
    end else begin
      col_pos_next = CAW'(col_inc);
      row_pos_next = ROW_W'(row_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_fire) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // item registers captured on the pixel transfer
  logic [PIXEL_BITS-1:0] px;
  logic [ROW_W-1:0]      row_reg;
  logic [CAW-1:0]        col_reg;
  logic                  produce;
  logic                  zero_mag;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px       <= pixels.pixel;
      row_reg  <= ROW_W'(row_cur);
      col_reg  <= CAW'(col_cur);
      produce  <= (row_cur != '0) && (col_cur != '0);
      zero_mag <= (row_cur == ROWS_CFG_W'(1)) || (col_cur == CCW'(1));
    end
  end

  // ------------------------------------------------------------------
  // line store: {older row, previous row} per column; read on transfer,
  // written back in the next cycle, so a read never meets a pending write
  // ------------------------------------------------------------------
  logic [2*PIXEL_BITS-1:0] line_rd;
  logic [PIXEL_BITS-1:0]   top_px;
  logic [PIXEL_BITS-1:0]   mid_px;

  assign top_px = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px = line_rd[PIXEL_BITS-1:0];

  sbl_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk     (clk),
    .wr_en   (state == S_RD),
    .wr_addr (col_reg),
    .wr_data ({mid_px, px}),
    .rd_en   (in_fire),
    .rd_addr (CAW'(col_cur)),
    .rd_data (line_rd)
  );

  // ------------------------------------------------------------------
  // window: columns c-2 (w[0..2]) and c-1 (w[3..5]), rows top/mid/bottom
  // ------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] win [6];
  logic [AW-1:0]         bot_sum;
  logic [AW-1:0]         top_sum;
  logic [AW-1:0]         right_sum;
  logic [AW-1:0]         left_sum;
  logic [AW-1:0]         ax;
  logic [AW-1:0]         ay;

  always_comb begin
    bot_sum   = AW'(win[2]) + (AW'(win[5]) << 1) + AW'(px);
    top_sum   = AW'(win[0]) + (AW'(win[3]) << 1) + AW'(top_px);
    right_sum = AW'(top_px) + (AW'(mid_px) << 1) + AW'(px);
    left_sum  = AW'(win[0]) + (AW'(win[1]) << 1) + AW'(win[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (state == S_RD) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_px;
      win[4] <= mid_px;
      win[5] <= px;
    end
  end

  // absolute gradients, squares and frame-end flag
  logic [SQW-1:0] sqx;
  logic [SQW-1:0] sqy;
  logic           last_reg;

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      ax       <= (bot_sum >= top_sum) ? bot_sum - top_sum : top_sum - bot_sum;
      ay       <= (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
      last_reg <= ({1'b0, row_reg} == rows_eff - 1'b1) && (CCW'(col_reg) == cols_eff - 1'b1);
    end
    if (state == S_SQ) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
  end

  // ------------------------------------------------------------------
  // square root unit
  // ------------------------------------------------------------------
  logic            sq_start;
  logic            sq_busy;
  logic            sq_done;
  logic [RADW-1:0] sq_rad;
  logic [RW-1:0]   sq_root;

  assign sq_start = (state == S_SUM);
  assign sq_rad   = RADW'(sqx) + RADW'(sqy);

  sbl_isqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // ------------------------------------------------------------------
  // output register: holds a finished result while the next pixel transfers
  // ------------------------------------------------------------------
  logic             res_valid;
  logic             out_free;
  logic             out_load;
  logic [MAG_W-1:0] res_mag;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic             res_last;
  logic [ROW_W-1:0] row_m1;
  logic [CAW-1:0]   col_m1;

  assign out_free = !res_valid || results.ready;
  assign out_load = (state == S_OUT) && out_free;
  assign row_m1   = row_reg - 1'b1;
  assign col_m1   = col_reg - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_mag  <= zero_mag ? '0 : MAG_W'(sq_root);
      res_row  <= row_m1;
      res_col  <= COL_W'(col_m1);
      res_last <= last_reg;
    end
  end

  assign results.valid      = res_valid;
  assign results.magnitude  = res_mag;
  assign results.centre_row = res_row;
  assign results.centre_col = res_col;
  assign results.frame_last = res_last;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_RD;
      S_RD: begin
        if (!produce) begin
          state_next = S_IDLE;
        end else if (zero_mag) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ:   state_next = S_SUM;
      S_SUM:  state_next = S_SQRT;
      S_SQRT: if (sq_done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `SBL_ASSERT_NEXT(a_fire_reads_line, in_fire, state == S_RD, "transfer not followed by line read")
  `SBL_ASSERT_NOW(a_idle_sqrt_quiet, state == S_IDLE, !sq_busy && !sq_done, "root busy while idle")
  `SBL_ASSERT_NOW(a_done_in_wait, sq_done, state == S_SQRT, "root finished outside its wait state")

endmodule

@@ rtl/sbl_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sbl_isqrt.sv @@
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps
module sbl_isqrt #(
  parameter int RW = 19
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            busy,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW+1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;

  // bring down the next two radicand bits and try a one in the next root bit
  assign rem_sh = {rem[RW-1:0], rad[2*RW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNTW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CNTW'(RW);
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      cnt <= cnt - 1'b1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule
